>>> design/kwm_pkg.sv
// Shared types and constants for the k-way sorted run merge.
package kwm_pkg;

    // Fixed field widths of the word ports
    localparam int RUN_W     = 4;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 5;
    localparam int RUN_LIMIT = 16;

    // Reset value of the run count register
    localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

    // What the back end does with a queued word
    typedef enum logic [1:0] {
        K_DROP = 2'd0,
        K_LOAD = 2'd1,
        K_END  = 2'd2
    } t_kind;

    // One classified input word
    typedef struct packed {
        t_kind                    kind;
        logic [RUN_W-1:0]         run;
        logic signed [VAL_W-1:0]  value;
    } t_entry;

    // Queue status seen by the producer and the consumer
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> design/kwm_front.sv
// Front end: run count register and classification of input words.
module kwm_front
    import kwm_pkg::*;
#(
    parameter int NUM_RUNS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CNT_W-1:0]       i_cfg_num_runs,
    input  logic                   i_valid,
    input  logic [RUN_W-1:0]       i_run,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                   i_ended,
    input  t_q_stat                i_q_stat,
    output logic                   o_push,
    output t_entry                 o_entry,
    output logic [CNT_W-1:0]       o_count
);

    localparam int DEPTH = (NUM_RUNS < RUN_LIMIT) ? NUM_RUNS : RUN_LIMIT;

    logic [CNT_W-1:0] r_num_runs;

    // Hold the configured run count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_runs <= CNT_RESET;
        end else if (i_cfg_valid) begin
            r_num_runs <= i_cfg_num_runs;
        end
    end

    // Clamp the count to the range the storage supports
    always_comb begin
        if (r_num_runs == '0) begin
            o_count = CNT_W'(1);
        end else if (r_num_runs > CNT_W'(DEPTH)) begin
            o_count = CNT_W'(DEPTH);
        end else begin
            o_count = r_num_runs;
        end
    end

    // Classify the word and push it while the queue has room
    always_comb begin
        o_push        = i_valid && !i_q_stat.full;
        o_entry.run   = i_run;
        o_entry.value = i_value;
        if ({1'b0, i_run} >= o_count) begin
            o_entry.kind = K_DROP;
        end else if (i_ended) begin
            o_entry.kind = K_END;
        end else begin
            o_entry.kind = K_LOAD;
        end
    end

endmodule

>>> design/kwm_queue.sv
// Two-entry queue between the front end and the back end.
module kwm_queue
    import kwm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    input  logic    i_pop,
    output t_entry  o_entry,
    output t_q_stat o_stat
);

    t_entry     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_entry      = r_mem[r_rp];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

>>> design/kwm_back.sv
// Back end: run state, registered minimum tree and result register.
module kwm_back
    import kwm_pkg::*;
#(
    parameter int NUM_RUNS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [CNT_W-1:0]        i_count,
    input  t_q_stat                 i_q_stat,
    input  t_entry                  i_entry,
    output logic                    o_pop,
    input  logic                    i_stall,
    output logic                    o_valid,
    output logic signed [VAL_W-1:0] o_value_res,
    output logic [RUN_W-1:0]        o_source_run,
    output logic                    o_done_res
);

    localparam int DEPTH  = (NUM_RUNS < RUN_LIMIT) ? NUM_RUNS : RUN_LIMIT;
    localparam int IW     = $clog2(DEPTH);
    localparam int LEVELS = $clog2(DEPTH);
    localparam int PAD    = 1 << LEVELS;
    localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_TREE  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state                  r_state;
    logic [DEPTH-1:0]        r_finished;
    logic [DEPTH-1:0]        r_loaded;
    logic [LW-1:0]           r_level;
    logic signed [VAL_W-1:0] r_head [DEPTH];
    logic                    r_c_vld [PAD];
    logic signed [VAL_W-1:0] r_c_val [PAD];
    logic [IW-1:0]           r_c_idx [PAD];

    logic [DEPTH-1:0]        w_active;
    logic [DEPTH-1:0]        w_open;
    logic [DEPTH-1:0]        w_wait;
    logic                    w_out_free;
    logic [IW-1:0]           w_ri;
    logic                    w_apply;
    logic                    w_head_we;
    logic                    w_cand_load;
    logic                    w_tree_step;
    logic                    w_done_out;
    logic                    w_emit;
    logic                    w_pick [PAD/2];

    // Decode run masks and the actions of this cycle
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_active[i] = (CNT_W'(i) < i_count);
        end
        w_open      = w_active & ~r_finished;
        w_wait      = w_open & ~r_loaded;
        w_out_free  = !o_valid || !i_stall;
        w_ri        = i_entry.run[IW-1:0];
        o_pop       = (r_state == S_IDLE) && !i_q_stat.empty;
        w_apply     = o_pop && (i_entry.kind != K_DROP)
                      && !r_loaded[w_ri] && !r_finished[w_ri];
        w_head_we   = w_apply && (i_entry.kind == K_LOAD);
        w_done_out  = (r_state == S_CHECK) && (w_wait == '0) && (w_open == '0)
                      && w_out_free;
        w_cand_load = (r_state == S_CHECK) && (w_wait == '0) && (w_open != '0);
        w_tree_step = (r_state == S_TREE);
        w_emit      = (r_state == S_EMIT) && w_out_free;
    end

    // Pick the better of each pair; the lower index wins a tie
    always_comb begin
        for (int i = 0; i < PAD / 2; i++) begin
            w_pick[i] = !r_c_vld[2*i]
                        || (r_c_vld[2*i+1] && (r_c_val[2*i+1] < r_c_val[2*i]));
        end
    end

    // Sequence one word: apply it, check readiness, reduce, emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_finished <= '0;
            r_loaded   <= '0;
            r_level    <= '0;
            o_valid    <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (w_apply) begin
                            if (i_entry.kind == K_END) begin
                                r_finished[w_ri] <= 1'b1;
                            end else begin
                                r_loaded[w_ri] <= 1'b1;
                            end
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_wait != '0) begin
                        r_state <= S_IDLE;
                    end else if (w_cand_load) begin
                        r_level <= '0;
                        r_state <= S_TREE;
                    end else if (w_done_out) begin
                        o_valid    <= 1'b1;
                        r_finished <= '0;
                        r_loaded   <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                S_TREE: begin
                    if (r_level == LW'(LEVELS - 1)) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_level <= r_level + LW'(1);
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        o_valid             <= 1'b1;
                        r_loaded[r_c_idx[0]] <= 1'b0;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Write the head of the refilled run
    always_ff @(posedge i_clk) begin
        if (w_head_we) begin
            r_head[w_ri] <= i_entry.value;
        end
    end

    // Load the candidate row, then halve it once a cycle
    always_ff @(posedge i_clk) begin
        if (w_cand_load) begin
            for (int i = 0; i < PAD; i++) begin
                r_c_idx[i] <= IW'(i);
                if (i < DEPTH) begin
                    r_c_vld[i] <= w_open[i];
                    r_c_val[i] <= r_head[i];
                end else begin
                    r_c_vld[i] <= 1'b0;
                    r_c_val[i] <= '0;
                end
            end
        end else if (w_tree_step) begin
            for (int i = 0; i < PAD / 2; i++) begin
                if (w_pick[i]) begin
                    r_c_vld[i] <= r_c_vld[2*i+1];
                    r_c_val[i] <= r_c_val[2*i+1];
                    r_c_idx[i] <= r_c_idx[2*i+1];
                end else begin
                    r_c_vld[i] <= r_c_vld[2*i];
                    r_c_val[i] <= r_c_val[2*i];
                    r_c_idx[i] <= r_c_idx[2*i];
                end
            end
        end
    end

    // Fill the result register
    always_ff @(posedge i_clk) begin
        if (w_done_out) begin
            o_value_res  <= '0;
            o_source_run <= '0;
            o_done_res   <= 1'b1;
        end else if (w_emit) begin
            o_value_res  <= r_c_val[0];
            o_source_run <= RUN_W'(r_c_idx[0]);
            o_done_res   <= 1'b0;
        end
    end

endmodule

>>> design/k_way_sorted_run_merge.sv
// Top level of the k-way sorted run merge.
//
// Merges up to 16 ascending runs of signed 32-bit values into one ascending
// word stream. Each input word names a run and carries its next head value,
// or marks the run as ended. Once every taking-part run holds a head or has
// ended, the smallest head leaves on the result channel with the run that
// must be refilled next; ties go to the lowest run. When all runs have
// ended a done word leaves and all run state clears.
// Channels: input words on i_valid / o_stall, results on o_valid / i_stall,
// the run count on i_cfg_valid / o_cfg_ready (always ready).
// Timing: a front end classifies words into a two-entry queue; the back end
// takes a word and checks the runs. When a result is produced, it reduces the
// heads through the registered minimum tree, one level per cycle, before the
// result register is loaded. It takes no new word until it is back in idle.
// Reset (synchronous, active low) clears all run state, sets the run count
// to 16 and empties the queue and the result register.
// While i_stall is high the result word holds; the back end waits for the
// register and the queue fills, then o_stall rises.
module k_way_sorted_run_merge
    import kwm_pkg::*;
#(
    parameter int NUM_RUNS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CNT_W-1:0]        i_cfg_num_runs,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [RUN_W-1:0]        i_run,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_ended,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [VAL_W-1:0] o_value_res,
    output logic [RUN_W-1:0]        o_source_run,
    output logic                    o_done_res
);

    t_entry           w_push_entry;
    t_entry           w_pop_entry;
    t_q_stat          w_q_stat;
    logic             w_push;
    logic             w_pop;
    logic [CNT_W-1:0] w_count;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = w_q_stat.full;

    kwm_front #(
        .NUM_RUNS (NUM_RUNS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_num_runs (i_cfg_num_runs),
        .i_valid        (i_valid),
        .i_run          (i_run),
        .i_value        (i_value),
        .i_ended        (i_ended),
        .i_q_stat       (w_q_stat),
        .o_push         (w_push),
        .o_entry        (w_push_entry),
        .o_count        (w_count)
    );

    kwm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_pop_entry),
        .o_stat  (w_q_stat)
    );

    kwm_back #(
        .NUM_RUNS (NUM_RUNS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_count      (w_count),
        .i_q_stat     (w_q_stat),
        .i_entry      (w_pop_entry),
        .o_pop        (w_pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_value_res  (o_value_res),
        .o_source_run (o_source_run),
        .o_done_res   (o_done_res)
    );

endmodule

>>> design/kwm_checker.sv
// Port-level checks for the k-way sorted run merge, bound to the top level.
module kwm_checker
    import kwm_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_cfg_valid,
    input logic                    o_cfg_ready,
    input logic [CNT_W-1:0]        i_cfg_num_runs,
    input logic                    i_valid,
    input logic                    o_stall,
    input logic [RUN_W-1:0]        i_run,
    input logic signed [VAL_W-1:0] i_value,
    input logic                    i_ended,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic signed [VAL_W-1:0] o_value_res,
    input logic [RUN_W-1:0]        o_source_run,
    input logic                    o_done_res
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value_res)
                               && $stable(o_source_run) && $stable(o_done_res))
        else $error("result word changed while stalled");

    // A done word carries zero value and run
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> (o_value_res == '0) && (o_source_run == '0))
        else $error("done word carries a value");

    // Reset empties the result register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Reset empties the queue, so the input side is open
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

endmodule

bind k_way_sorted_run_merge kwm_checker u_kwm_checker (.*);

>>> bench/tb_k_way_sorted_run_merge.sv
// Self-checking testbench for the k-way sorted run merge, with its own merge predictor.
`timescale 1ns / 100ps

module tb_k_way_sorted_run_merge;
    import kwm_pkg::*;

    localparam int                 LATENCY_WAIT   = 40;
    localparam int                 WATCHDOG_LIMIT = 5000;
    localparam int                 PHASE_WORDS    = 60;
    localparam logic signed [31:0] INT_MAX        = 32'sh7fffffff;
    localparam logic signed [31:0] INT_MIN        = 32'sh80000000;

    // One merged output word
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [RUN_W-1:0]        run;
        logic                    done;
    } t_merge_word;

    // Tracks run heads and the merged words still to arrive
    class t_merge_scoreboard;
        logic signed [VAL_W-1:0] head_val [RUN_LIMIT];
        bit                      run_ended [RUN_LIMIT];
        bit                      head_full [RUN_LIMIT];
        logic [CNT_W-1:0]        run_count;
        t_merge_word             words_due [$];
        int                      errors;
        int                      merges;
        int                      values_out;

        function new();
            clear_runs();
            run_count  = CNT_RESET;
            errors     = 0;
            merges     = 0;
            values_out = 0;
        endfunction

        function void clear_runs();
            foreach (head_val[i]) begin
                head_val[i]  = '0;
                run_ended[i] = 1'b0;
                head_full[i] = 1'b0;
            end
        endfunction

        // Clamp the register to the runs that actually take part
        function int taking_part();
            int n;
            n = run_count;
            if (n == 0) n = 1;
            if (n > RUN_LIMIT) n = RUN_LIMIT;
            return n;
        endfunction

        function bit waiting(int r);
            return r < taking_part() && !head_full[r] && !run_ended[r];
        endfunction

        function bit at_rest();
            foreach (head_full[i]) begin
                if (head_full[i] || run_ended[i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        // Apply one accepted word; queue the merged word it causes, if any
        function bit note_input(logic [RUN_W-1:0] run, logic signed [VAL_W-1:0] value,
                                logic ended);
            int          n;
            int          best;
            bit          took;
            bit          all_ended;
            t_merge_word w;
            n    = taking_part();
            took = waiting(run);
            if (took) begin
                if (ended) begin
                    run_ended[run] = 1'b1;
                end else begin
                    head_val[run]  = value;
                    head_full[run] = 1'b1;
                end
            end
            all_ended = 1'b1;
            for (int i = 0; i < n; i++) begin
                if (!run_ended[i]) begin
                    all_ended = 1'b0;
                    if (!head_full[i]) return took;
                end
            end
            w = '0;
            if (all_ended) begin
                clear_runs();
                w.done = 1'b1;
                words_due.push_back(w);
                merges++;
                return took;
            end
            // Smallest head wins; strict compare keeps the lowest run on a tie
            best = -1;
            for (int i = 0; i < n; i++) begin
                if (!run_ended[i] && head_full[i] && (best < 0 || head_val[i] < head_val[best]))
                    best = i;
            end
            head_full[best] = 1'b0;
            w.value = head_val[best];
            w.run   = best[RUN_W-1:0];
            words_due.push_back(w);
            values_out++;
            return took;
        endfunction

        function void check_result(logic signed [VAL_W-1:0] value, logic [RUN_W-1:0] run,
                                   logic done);
            t_merge_word w;
            if (words_due.size() == 0) begin
                $error("unexpected result word: value_res %0d source_run %0d done_res %0d",
                       value, run, done);
                errors++;
                return;
            end
            w = words_due.pop_front();
            if (value !== w.value) begin
                $error("value_res: expected %0d, got %0d", w.value, value);
                errors++;
            end
            if (run !== w.run) begin
                $error("source_run: expected %0d, got %0d", w.run, run);
                errors++;
            end
            if (done !== w.done) begin
                $error("done_res: expected %0d, got %0d", w.done, done);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_cfg_valid    = 1'b0;
    logic                    o_cfg_ready;
    logic [CNT_W-1:0]        i_cfg_num_runs = '0;
    logic                    i_valid        = 1'b0;
    logic                    o_stall;
    logic [RUN_W-1:0]        i_run          = '0;
    logic signed [VAL_W-1:0] i_value        = '0;
    logic                    i_ended        = 1'b0;
    logic                    o_valid;
    logic                    i_stall        = 1'b0;
    logic signed [VAL_W-1:0] o_value_res;
    logic [RUN_W-1:0]        o_source_run;
    logic                    o_done_res;

    t_merge_scoreboard       sb = new();
    int                      idle_pct    = 0;
    int                      stall_pct   = 0;
    int                      words_in    = 0;
    int                      words_took  = 0;
    int                      quiet_count = 0;
    int                      settings    = 0;
    logic signed [VAL_W-1:0] last_val [RUN_LIMIT];
    bit                      started [RUN_LIMIT];

    k_way_sorted_run_merge dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_num_runs (i_cfg_num_runs),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_run          (i_run),
        .i_value        (i_value),
        .i_ended        (i_ended),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_value_res    (o_value_res),
        .o_source_run   (o_source_run),
        .o_done_res     (o_done_res)
    );

    always #5 i_clk = ~i_clk;

    // Take result words and stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_value_res, o_source_run, o_done_res);
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Abort when no channel moves a word for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_count <= 0;
        end else if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("k_way_sorted_run_merge: mismatch");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    // Offer one word after a random gap and hold it until accepted
    task automatic push_word(input logic [RUN_W-1:0] run, input logic signed [VAL_W-1:0] value,
                             input logic ended);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_run   <= run;
        i_value <= value;
        i_ended <= ended;
        do @(posedge i_clk); while (o_stall);
        words_in++;
        if (sb.note_input(run, value, ended)) words_took++;
    endtask

    task automatic quiet_input();
        i_valid <= 1'b0;
    endtask

    // Drain outstanding words, then allow for work that leaves no word
    task automatic wait_idle();
        while (sb.words_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
    endtask

    task automatic write_run_count(input logic [CNT_W-1:0] count);
        i_cfg_valid    <= 1'b1;
        i_cfg_num_runs <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.run_count = count;
        settings++;
        i_cfg_valid <= 1'b0;
    endtask

    // Feed well-formed ascending runs with some noise until the quota is met
    // and the current merge has closed
    task automatic run_merges(input int quota);
        int              first_took;
        int              r;
        int              ready_runs [$];
        longint          nv;
        logic            e;
        first_took = words_took;
        do begin
            if (sb.at_rest()) begin
                foreach (started[i]) started[i] = 1'b0;
            end
            if ($urandom_range(0, 9) == 0) begin
                push_word(RUN_W'($urandom_range(0, 15)), $urandom, $urandom_range(0, 3) == 0);
            end else begin
                ready_runs.delete();
                for (int i = 0; i < sb.taking_part(); i++) begin
                    if (sb.waiting(i)) ready_runs.push_back(i);
                end
                r = ready_runs[$urandom_range(0, ready_runs.size() - 1)];
                if (!started[r]) begin
                    started[r] = 1'b1;
                    e = ($urandom_range(0, 9) == 0);
                    case ($urandom_range(0, 7))
                        0:       nv = INT_MIN;
                        1:       nv = -1;
                        default: nv = $signed($urandom);
                    endcase
                end else begin
                    e = ($urandom_range(0, 4) == 0);
                    case ($urandom_range(0, 19)) inside
                        0:       nv = INT_MAX;
                        [1:3]:   nv = longint'(last_val[r])
                                      + longint'($urandom_range(0, 32'h7fffffff));
                        default: nv = longint'(last_val[r]) + longint'($urandom_range(0, 1000));
                    endcase
                    if (nv > INT_MAX) nv = INT_MAX;
                end
                last_val[r] = nv[31:0];
                push_word(r[RUN_W-1:0], nv[31:0], e);
            end
        end while (words_took - first_took < quota || !sb.at_rest());
    endtask

    initial begin
        logic [CNT_W-1:0] phase_count [8];
        phase_count = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd2, 5'd16, 5'd9};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // Ties, extremes, an out-of-range run, a loaded run and an ended run
        write_run_count(5'd3);
        push_word(4'd0, 32'sd5, 1'b0);
        push_word(4'd1, 32'sd5, 1'b0);
        push_word(4'd5, 32'sd7, 1'b0);
        push_word(4'd0, 32'sd9, 1'b0);
        push_word(4'd2, INT_MIN, 1'b0);
        push_word(4'd2, INT_MAX, 1'b0);
        push_word(4'd0, 32'sd5, 1'b0);
        push_word(4'd0, 32'sd0, 1'b1);
        push_word(4'd0, 32'sd3, 1'b0);
        push_word(4'd1, INT_MAX, 1'b0);
        push_word(4'd1, 32'sd0, 1'b1);
        push_word(4'd2, 32'sd0, 1'b1);

        // Shrink the run count with a merge half loaded
        push_word(4'd0, 32'sd1, 1'b0);
        push_word(4'd1, 32'sd2, 1'b0);
        quiet_input();
        wait_idle();
        write_run_count(5'd2);
        push_word(4'd2, -32'sd1, 1'b0);
        push_word(4'd0, 32'sd0, 1'b1);
        push_word(4'd1, 32'sd0, 1'b1);
        quiet_input();
        wait_idle();

        // A lone run
        write_run_count(5'd1);
        push_word(4'd0, 32'sd0, 1'b0);
        push_word(4'd0, -32'sd1, 1'b0);
        push_word(4'd0, 32'sd0, 1'b1);
        quiet_input();

        // Random merges over run counts and idling patterns
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            write_run_count(phase_count[p]);
            case (p / 2)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            run_merges(PHASE_WORDS);
            quiet_input();
        end

        idle_pct  = 0;
        stall_pct = 0;
        wait_idle();
        $display("run covered %0d input words (%0d took effect) over %0d run count settings",
                 words_in, words_took, settings);
        $display("%0d values merged, %0d merges closed with a done word",
                 sb.values_out, sb.merges);
        if (sb.errors == 0)
            $display("k_way_sorted_run_merge: match");
        else
            $display("k_way_sorted_run_merge: mismatch");
        $finish;
    end

endmodule
